>>> rtl/hfr_pkg.sv
package hfr_pkg;

  // Default for the longest frame, in decoded bytes including the command and checksum
  localparam int unsigned MaxBytesDef = 128;

  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] SumTarget = 8'h55;

  localparam logic [15:0] HistLo = 16'h1050;
  localparam logic [15:0] HistHi = 16'h106E;

  localparam logic [15:0] VerMask     = 16'h3FFF;
  localparam logic [7:0]  VerPingMask = 8'h3F;

  // Width of the packed result word
  localparam int unsigned ResBits  = 102;
  localparam int unsigned ResBytes = (ResBits + 7) / 8;
  localparam int unsigned ResTdataW = ResBytes * 8;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_CHECKSUM = 3'd2,
    ST_ODD_HEX  = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    MC_DONE    = 3'd0,
    MC_UNKNOWN = 3'd1,
    MC_ERROR   = 3'd2,
    MC_PING    = 3'd3,
    MC_GET     = 3'd4,
    MC_SET     = 3'd5,
    MC_ASYNC   = 3'd6,
    MC_OTHER   = 3'd7
  } msg_class_e;

  typedef enum logic [3:0] {
    CMD_DONE    = 4'h1,
    CMD_UNKNOWN = 4'h3,
    CMD_ERROR   = 4'h4,
    CMD_PING    = 4'h5,
    CMD_GET     = 4'h7,
    CMD_SET     = 4'h8,
    CMD_ASYNC   = 4'hA
  } cmd_e;

  // Frame contents as seen when the newline arrives
  typedef struct packed {
    logic [3:0]  command;
    logic [15:0] word;
    logic [7:0]  flag;
    logic [31:0] value;
    logic [7:0]  last_byte;
    logic [7:0]  byte_sum;
    logic        overflowed;
    logic        odd_nibble;
    logic        too_short;
    logic [2:0]  value_bytes;
    logic [7:0]  count_lo;
  } frame_snap_t;

  typedef struct packed {
    logic [7:0]  byte_count;
    logic [7:0]  received_checksum;
    logic        history_day;
    logic [2:0]  value_bytes;
    logic [31:0] value_word;
    logic [7:0]  flag_byte;
    logic [13:0] version;
    logic [1:0]  app_type;
    logic [15:0] register_word;
    msg_class_e  message_class;
    logic [3:0]  command;
    status_e     status;
  } result_t;

endpackage

>>> rtl/hfr_frame.sv
module hfr_frame import hfr_pkg::*; #(
  parameter int unsigned MaxBytes = MaxBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  char_i,
  output logic        eol_o,
  output frame_snap_t snap_o
);

  localparam int unsigned CntW = $clog2(MaxBytes + 1);

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] n;
    n = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) n = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) n = 4'(c - 8'h37);
    return n;
  endfunction

  logic            in_frame_q, in_frame_d;
  logic            phase_q, phase_d;
  logic [3:0]      high_q, high_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      sum_q, sum_d;
  logic [3:0]      cmd_q, cmd_d;
  logic [15:0]     word_q, word_d;
  logic [7:0]      flag_q, flag_d;
  logic [31:0]     value_q, value_d;
  logic [7:0]      last_q, last_d;
  logic            ovf_q, ovf_d;

  logic [3:0] nib;
  logic [7:0] new_byte;

  assign nib      = hex_nibble(char_i);
  assign new_byte = {high_q, nib};
  assign eol_o    = in_frame_q && (char_i == ChNewline);

  always_comb begin
    in_frame_d = in_frame_q;
    phase_d    = phase_q;
    high_d     = high_q;
    count_d    = count_q;
    sum_d      = sum_q;
    cmd_d      = cmd_q;
    word_d     = word_q;
    flag_d     = flag_q;
    value_d    = value_q;
    last_d     = last_q;
    ovf_d      = ovf_q;
    if (char_i == ChColon || eol_o) begin
      // colon opens (or restarts) a frame, newline closes it
      in_frame_d = (char_i == ChColon);
      phase_d    = 1'b0;
      high_d     = '0;
      count_d    = '0;
      sum_d      = '0;
      cmd_d      = '0;
      word_d     = '0;
      flag_d     = '0;
      value_d    = '0;
      last_d     = '0;
      ovf_d      = 1'b0;
    end else if (in_frame_q) begin
      if (count_q == '0) begin
        cmd_d   = nib;
        sum_d   = {4'h0, nib};
        last_d  = {4'h0, nib};
        count_d = CntW'(1);
      end else if (!phase_q) begin
        high_d  = nib;
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        if (count_q >= CntW'(MaxBytes)) begin
          ovf_d = 1'b1;
        end else begin
          if (count_q == CntW'(1)) word_d[7:0] = new_byte;
          else if (count_q == CntW'(2)) word_d[15:8] = new_byte;
          else if (count_q == CntW'(3)) flag_d = new_byte;
          else if (count_q >= CntW'(4) && count_q <= CntW'(7)) begin
            value_d[8*count_q[1:0] +: 8] = new_byte;
          end
          sum_d   = sum_q + new_byte;
          last_d  = new_byte;
          count_d = count_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      phase_q    <= 1'b0;
      high_q     <= '0;
      count_q    <= '0;
      sum_q      <= '0;
      cmd_q      <= '0;
      word_q     <= '0;
      flag_q     <= '0;
      value_q    <= '0;
      last_q     <= '0;
      ovf_q      <= 1'b0;
    end else if (step_i) begin
      in_frame_q <= in_frame_d;
      phase_q    <= phase_d;
      high_q     <= high_d;
      count_q    <= count_d;
      sum_q      <= sum_d;
      cmd_q      <= cmd_d;
      word_q     <= word_d;
      flag_q     <= flag_d;
      value_q    <= value_d;
      last_q     <= last_d;
      ovf_q      <= ovf_d;
    end
  end

  always_comb begin
    snap_o.command    = cmd_q;
    snap_o.word       = word_q;
    snap_o.flag       = flag_q;
    snap_o.value      = value_q;
    snap_o.last_byte  = last_q;
    snap_o.byte_sum   = sum_q;
    snap_o.overflowed = ovf_q;
    snap_o.odd_nibble = phase_q;
    snap_o.too_short  = (count_q < CntW'(2));
    snap_o.count_lo   = 8'(count_q);
    // data bytes start at byte 4 and the last stored byte is the checksum
    if (count_q >= CntW'(9)) snap_o.value_bytes = 3'd4;
    else if (count_q >= CntW'(6)) snap_o.value_bytes = 3'(count_q - CntW'(5));
    else snap_o.value_bytes = 3'd0;
  end

endmodule

>>> rtl/hfr_result.sv
module hfr_result import hfr_pkg::*; (
  input  frame_snap_t snap_i,
  output result_t     res_o
);

  function automatic msg_class_e class_of(input logic [3:0] cmd);
    msg_class_e c;
    unique case (cmd)
      CMD_DONE:    c = MC_DONE;
      CMD_UNKNOWN: c = MC_UNKNOWN;
      CMD_ERROR:   c = MC_ERROR;
      CMD_PING:    c = MC_PING;
      CMD_GET:     c = MC_GET;
      CMD_SET:     c = MC_SET;
      CMD_ASYNC:   c = MC_ASYNC;
      default:     c = MC_OTHER;
    endcase
    return c;
  endfunction

  msg_class_e  cls;
  logic [1:0]  app;
  logic [31:0] vmask;

  assign cls = class_of(snap_i.command);
  assign app = snap_i.word[15:14];

  always_comb begin
    unique case (snap_i.value_bytes)
      3'd0:    vmask = 32'h0000_0000;
      3'd1:    vmask = 32'h0000_00FF;
      3'd2:    vmask = 32'h0000_FFFF;
      3'd3:    vmask = 32'h00FF_FFFF;
      default: vmask = 32'hFFFF_FFFF;
    endcase
  end

  always_comb begin
    priority if (snap_i.overflowed)          res_o.status = ST_OVERFLOW;
    else if (snap_i.too_short)               res_o.status = ST_SHORT;
    else if (snap_i.odd_nibble)              res_o.status = ST_ODD_HEX;
    else if (snap_i.byte_sum != SumTarget)   res_o.status = ST_CHECKSUM;
    else                                     res_o.status = ST_OK;

    res_o.command       = snap_i.command;
    res_o.message_class = cls;
    res_o.register_word = snap_i.word;
    res_o.app_type      = app;
    // version: application type 3 keeps only six bits of the low byte, for any command
    if (app == 2'b11) res_o.version = 14'({8'h00, snap_i.word[7:0] & VerPingMask});
    else res_o.version = 14'(snap_i.word & VerMask);
    res_o.flag_byte         = snap_i.flag;
    res_o.value_word        = snap_i.value & vmask;
    res_o.value_bytes       = snap_i.value_bytes;
    res_o.history_day       = (cls == MC_GET || cls == MC_ASYNC) &&
                              snap_i.word >= HistLo && snap_i.word <= HistHi;
    res_o.received_checksum = snap_i.last_byte;
    res_o.byte_count        = snap_i.count_lo;
  end

endmodule

>>> rtl/hex_frame_receiver_unit.sv
// ASCII hex frame receiver. One received character enters per word on the slave
// stream; frames look like ':' <command digit> <hex pairs> '\n'. A result word
// leaves on the master stream only for a newline inside a frame. It carries a
// status (ok, too short, checksum error, odd hex count, overflow), the command
// and its class, decoded payload fields and the byte count. Rate is one
// character per clock: the character waits in an input register, the frame
// state advances from it, and the decoded result lands in the output register
// when the newline steps out of the input register. The input side stalls
// only when a newline is waiting and the output register still holds an
// untaken result. MaxBytes sets the frame length limit.
module hex_frame_receiver_unit import hfr_pkg::*; #(
  parameter int unsigned MaxBytes = MaxBytesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [7:0]           s_tdata_i,   // [7:0] rx_char
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  // [2:0] status, [6:3] command, [9:7] message_class, [25:10] register_word,
  // [27:26] app_type, [41:28] version, [49:42] flag_byte, [81:50] value_word,
  // [84:82] value_bytes, [85] history_day, [93:86] received_checksum,
  // [101:94] byte_count, [103:102] zero
  output logic [ResTdataW-1:0] m_tdata_o
);

  // input register
  logic       in_vld_q;
  logic [7:0] in_char_q;

  // frame state interface
  logic        eol;
  logic        step;
  frame_snap_t snap;
  result_t     res;

  // output register
  logic    out_vld_q;
  result_t out_q;

  // A character moves on unless it is a newline closing a frame while the output register holds an untaken result.
  assign step       = in_vld_q && (!eol || !out_vld_q || m_tready_i);
  assign s_tready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_tready_o) begin
      in_vld_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_char_q <= s_tdata_i;
    end
  end

  hfr_frame #(
    .MaxBytes(MaxBytes)
  ) u_frame (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .char_i(in_char_q),
    .eol_o (eol),
    .snap_o(snap)
  );

  hfr_result u_result (
    .snap_i(snap),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && eol) begin
      out_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && eol) begin
      out_q <= res;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {{(ResTdataW - ResBits){1'b0}},
                       out_q.byte_count, out_q.received_checksum, out_q.history_day,
                       out_q.value_bytes, out_q.value_word, out_q.flag_byte,
                       out_q.version, out_q.app_type, out_q.register_word,
                       out_q.message_class, out_q.command, out_q.status};

`ifndef ASSERT_OFF
  a_eol_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && eol |=> out_vld_q)
    else $error("newline did not load a result");

  a_no_step_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && eol && out_vld_q && !m_tready_i |-> !s_tready_o)
    else $error("input taken while a newline is blocked");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.status == ST_OK || out_q.status == ST_SHORT ||
                   out_q.status == ST_CHECKSUM || out_q.status == ST_ODD_HEX ||
                   out_q.status == ST_OVERFLOW))
    else $error("status code out of range");

  a_history_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.history_day |->
      (out_q.message_class == MC_GET || out_q.message_class == MC_ASYNC))
    else $error("history marker on wrong message class");

  a_value_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.value_bytes != 3'd0 |-> !$isunknown(out_q.value_word) &&
      out_q.value_bytes <= 3'd4)
    else $error("value byte count out of range");
`endif

endmodule

>>> test/hex_frame_receiver_unit_tb.sv
`timescale 1ns / 1ps

module hex_frame_receiver_unit_tb;
  import hfr_pkg::*;

  localparam int unsigned FrameMax      = MaxBytesDef;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned IdlePct       = 31;

  // characters used to build lines
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperF = 8'h46;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerX = 8'h78;
  localparam logic [7:0] ChCr     = 8'h0D;

  localparam cmd_e CmdList [7] = '{CMD_DONE, CMD_UNKNOWN, CMD_ERROR, CMD_PING,
                                   CMD_GET, CMD_SET, CMD_ASYNC};

  logic                 clk_i;
  logic                 rst_ni     = 1'b0;
  logic                 s_tvalid_i = 1'b0;
  logic [7:0]           s_tdata_i  = 8'h00;
  logic                 s_tready_o;
  logic                 m_tvalid_o;
  logic                 m_tready_i = 1'b0;
  logic [ResTdataW-1:0] m_tdata_o;

  hex_frame_receiver_unit #(
    .MaxBytes(FrameMax)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Frame decoder mirror: state of the frame being received
  // ---------------------------------------------------------------------------
  logic        fr_in_frame;
  logic        fr_phase;
  logic [3:0]  fr_hi;
  int unsigned fr_count;
  logic [7:0]  fr_sum;
  logic [3:0]  fr_cmd;
  logic [15:0] fr_word;
  logic [7:0]  fr_flag;
  logic [31:0] fr_value;
  logic [7:0]  fr_last;
  logic        fr_ovf;

  result_t     frame_reports_q[$];
  int unsigned err_count    = 0;
  int unsigned results_seen = 0;
  int unsigned live_chars   = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle      = 1'b0;

  logic [7:0]  line_q[$];
  logic [7:0]  body_q[$];

  task automatic clear_frame();
    fr_phase = 1'b0;
    fr_hi    = '0;
    fr_count = 0;
    fr_sum   = '0;
    fr_cmd   = '0;
    fr_word  = '0;
    fr_flag  = '0;
    fr_value = '0;
    fr_last  = '0;
    fr_ovf   = 1'b0;
  endtask

  // Advance the mirror by one accepted character; a newline in a frame
  // queues the expected report.
  task automatic deframe_char(input logic [7:0] ch);
    logic [3:0]  nib;
    logic [7:0]  b;
    int unsigned vb;
    logic [31:0] vmask;
    result_t     r;
    if (ch == ChColon) begin
      fr_in_frame = 1'b1;
      clear_frame();
    end else if (fr_in_frame && ch != ChNewline) begin
      // upper-case hex only; anything else counts as zero
      if (ch >= ChZero && ch <= ChNine) nib = 4'(ch - ChZero);
      else if (ch >= ChUpperA && ch <= ChUpperF) nib = 4'(ch - ChUpperA + 8'd10);
      else nib = 4'd0;
      if (fr_count == 0) begin
        fr_cmd   = nib;
        fr_sum   = {4'd0, nib};
        fr_last  = {4'd0, nib};
        fr_count = 1;
      end else if (!fr_phase) begin
        fr_hi    = nib;
        fr_phase = 1'b1;
      end else begin
        fr_phase = 1'b0;
        b = {fr_hi, nib};
        if (fr_count >= FrameMax) begin
          fr_ovf = 1'b1;  // byte dropped, sum untouched
        end else begin
          case (fr_count)
            1: fr_word[7:0]  = b;
            2: fr_word[15:8] = b;
            3: fr_flag       = b;
            4, 5, 6, 7: fr_value[(fr_count - 4) * 8 +: 8] = b;
            default: ;
          endcase
          fr_sum   = fr_sum + b;
          fr_last  = b;
          fr_count = fr_count + 1;
        end
      end
    end else if (fr_in_frame) begin
      if (fr_ovf) r.status = ST_OVERFLOW;
      else if (fr_count < 2) r.status = ST_SHORT;
      else if (fr_phase) r.status = ST_ODD_HEX;
      else if (fr_sum != SumTarget) r.status = ST_CHECKSUM;
      else r.status = ST_OK;
      r.command = fr_cmd;
      case (fr_cmd)
        CMD_DONE:    r.message_class = MC_DONE;
        CMD_UNKNOWN: r.message_class = MC_UNKNOWN;
        CMD_ERROR:   r.message_class = MC_ERROR;
        CMD_PING:    r.message_class = MC_PING;
        CMD_GET:     r.message_class = MC_GET;
        CMD_SET:     r.message_class = MC_SET;
        CMD_ASYNC:   r.message_class = MC_ASYNC;
        default:     r.message_class = MC_OTHER;
      endcase
      r.register_word = fr_word;
      r.app_type      = fr_word[15:14];
      r.version       = (r.app_type == 2'd3) ? {6'd0, fr_word[7:0] & VerPingMask}
                                             : fr_word[13:0] & VerMask[13:0];
      r.flag_byte     = fr_flag;
      // data bytes sit before the checksum, at most four of them
      vb = 0;
      if (fr_count >= 6) vb = (fr_count - 5 > 4) ? 4 : fr_count - 5;
      vmask = (vb >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (vb * 8)) - 32'd1);
      r.value_word  = fr_value & vmask;
      r.value_bytes = 3'(vb);
      r.history_day = (r.message_class == MC_GET || r.message_class == MC_ASYNC) &&
                      fr_word >= HistLo && fr_word <= HistHi;
      r.received_checksum = fr_last;
      r.byte_count        = 8'(fr_count);
      frame_reports_q.push_back(r);
      fr_in_frame = 1'b0;
      clear_frame();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_error(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("report %0d %s: got %0h, expected %0h",
                             results_seen, name, got, want));
  endtask

  // outputs sampled at the edge, before the block's own updates land
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got = result_t'(m_tdata_o[ResBits-1:0]);
      results_seen++;
      if (frame_reports_q.size() == 0) begin
        report_error($sformatf("report %0d arrived with none pending", results_seen));
      end else begin
        want = frame_reports_q.pop_front();
        check_field("status", got.status, want.status);
        check_field("command", got.command, want.command);
        check_field("message_class", got.message_class, want.message_class);
        check_field("register_word", got.register_word, want.register_word);
        check_field("app_type", got.app_type, want.app_type);
        check_field("version", got.version, want.version);
        check_field("flag_byte", got.flag_byte, want.flag_byte);
        check_field("value_word", got.value_word, want.value_word);
        check_field("value_bytes", got.value_bytes, want.value_bytes);
        check_field("history_day", got.history_day, want.history_day);
        check_field("received_checksum", got.received_checksum, want.received_checksum);
        check_field("byte_count", got.byte_count, want.byte_count);
        check_field("padding", m_tdata_o[ResTdataW-1:ResBits], '0);
      end
    end
  end

  // random back-pressure, off during the no-idle stretch
  always @(posedge clk_i) m_tready_i <= no_idle || ($urandom_range(99) >= IdlePct);

  // ends the run if neither side moves a word for too long
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Called at a clock edge; returns at the edge where the word is taken.
  task automatic send_char(input logic [7:0] ch);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= ch;
    do @(posedge clk_i); while (!s_tready_o);
    if (fr_in_frame || ch == ChColon) live_chars++;
    deframe_char(ch);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_char(line_q[i]);
    line_q.delete();
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? ChZero + 8'(n) : ChUpperA + 8'(n - 4'd10);
  endfunction

  task automatic push_hex(input logic [7:0] b);
    line_q.push_back(hex_char(b[7:4]));
    line_q.push_back(hex_char(b[3:0]));
  endtask

  task automatic rand_body(input int unsigned n);
    body_q.delete();
    repeat (n) body_q.push_back(8'($urandom_range(255)));
  endtask

  // ':' cmd body checksum '\n' appended to line_q
  task automatic build_frame(input logic [3:0] cmd, input bit good_sum);
    logic [7:0] sum;
    logic [7:0] ck;
    sum = {4'd0, cmd};
    line_q.push_back(ChColon);
    line_q.push_back(hex_char(cmd));
    foreach (body_q[i]) begin
      push_hex(body_q[i]);
      sum = sum + body_q[i];
    end
    ck = SumTarget - sum;
    if (!good_sum) ck = ck ^ 8'($urandom_range(255, 1));
    push_hex(ck);
    line_q.push_back(ChNewline);
  endtask

  task automatic word_frame(input logic [3:0] cmd, input logic [15:0] w);
    rand_body(6);
    body_q[0] = w[7:0];
    body_q[1] = w[15:8];
    build_frame(cmd, 1'b1);
    send_line();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_all_commands();
    for (int c = 0; c < 16; c++) begin
      rand_body(4);
      if (c == 0) foreach (body_q[i]) body_q[i] = 8'h00;
      if (c == 15) foreach (body_q[i]) body_q[i] = 8'hFF;
      build_frame(4'(c), 1'b1);
      send_line();
    end
  endtask

  task automatic test_ping_and_history();
    word_frame(CMD_PING, 16'hC0FF);   // app type 3: version from low byte
    word_frame(CMD_PING, 16'h3FFF);
    word_frame(CMD_PING, 16'h8001);
    word_frame(CMD_GET, HistLo - 16'd1);
    word_frame(CMD_GET, HistLo);
    word_frame(CMD_GET, HistHi);
    word_frame(CMD_GET, HistHi + 16'd1);
    word_frame(CMD_ASYNC, HistLo + 16'd8);
    word_frame(CMD_SET, HistLo);      // in range but not a get
  endtask

  task automatic test_value_lengths();
    for (int n = 0; n <= 8; n++) begin
      rand_body(n);
      build_frame(CMD_GET, 1'b1);
      send_line();
    end
  endtask

  task automatic test_malformed();
    // junk outside any frame, newline included
    line_q = '{8'h00, 8'hFF, ChLowerX, ChNewline, ChCr};
    send_line();
    // empty frame and command only
    line_q = '{ChColon, ChNewline};
    send_line();
    line_q = '{ChColon, hex_char(CMD_GET), ChNewline};
    send_line();
    // dangling nibble after the command: short wins over odd
    line_q = '{ChColon, hex_char(CMD_GET), ChUpperA, ChNewline};
    send_line();
    line_q = '{ChColon, hex_char(CMD_GET), ChUpperA, ChZero + 8'd1, ChUpperF, ChNewline};
    send_line();
    rand_body(3);
    build_frame(CMD_SET, 1'b0);
    send_line();
    // second colon throws away the partial frame
    line_q = '{ChColon, hex_char(CMD_SET), ChUpperA, ChNine};
    rand_body(2);
    build_frame(CMD_PING, 1'b1);
    send_line();
    // carriage return before the newline leaves half a byte
    rand_body(2);
    build_frame(CMD_GET, 1'b1);
    line_q.insert(line_q.size() - 1, ChCr);
    send_line();
    // lower case and extreme codes decode to zero
    line_q = '{ChColon, ChLowerA, ChLowerA + 8'd1, ChLowerA + 8'd2, 8'hFF, 8'h00,
               ChNewline};
    send_line();
  endtask

  task automatic test_overflow();
    rand_body(FrameMax - 2);   // exactly full
    build_frame(CMD_SET, 1'b1);
    send_line();
    rand_body(FrameMax - 1);   // checksum byte falls off the end
    build_frame(CMD_SET, 1'b1);
    send_line();
    rand_body(FrameMax + 1);
    build_frame(CMD_ASYNC, 1'b1);
    send_line();
  endtask

  // Mostly well-formed frames with random content, some broken, some junk.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned len;
    int unsigned pos;
    logic [3:0]  cmd;
    logic [15:0] w;
    stop_at = live_chars + n_items;
    while (live_chars < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 85) begin
        cmd = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                       : CmdList[$urandom_range(6)];
        len = ($urandom_range(99) < 3) ? $urandom_range(FrameMax + 2, FrameMax - 4)
                                       : $urandom_range(10);
        rand_body(len);
        if (len >= 2 && (cmd == CMD_GET || cmd == CMD_ASYNC) && $urandom_range(9) < 4) begin
          w = HistLo - 16'd2 + 16'($urandom_range(HistHi - HistLo + 4));
          body_q[0] = w[7:0];
          body_q[1] = w[15:8];
        end
        if (len >= 2 && cmd == CMD_PING && $urandom_range(9) < 4) body_q[1][7:6] = 2'b11;
        build_frame(cmd, $urandom_range(99) < 85);
        if (kind >= 70) begin
          pos = $urandom_range(line_q.size() - 1, 1);
          case ($urandom_range(2))
            0:       line_q[pos] = 8'($urandom_range(255));
            1:       line_q.delete(pos);
            default: line_q.insert(pos, 8'($urandom_range(255)));
          endcase
        end
      end else begin
        repeat ($urandom_range(6, 1)) line_q.push_back(8'($urandom_range(255)));
      end
      send_line();
    end
  endtask

  task automatic test_back_to_back(input int unsigned n_items);
    no_idle = 1'b1;
    test_random_traffic(n_items);
    no_idle = 1'b0;
  endtask

  initial begin
    fr_in_frame = 1'b0;
    clear_frame();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_all_commands();
    test_ping_and_history();
    test_value_lengths();
    test_malformed();
    test_overflow();
    test_random_traffic(300);
    test_back_to_back(200);
    test_random_traffic(300);

    s_tvalid_i <= 1'b0;
    while (frame_reports_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
